@@ hdl/pidsr_pkg.sv @@
// Shared types, widths and constants of the PID step rate controller.
package pidsr_pkg;

    // Field and state widths.
    localparam int POSITION_BITS = 24;
    localparam int ERR_W         = POSITION_BITS + 1;
    localparam int SUM_W         = 25;
    localparam int LIMIT_W       = 24;
    localparam int GAIN_W        = 16;
    localparam int ELAPSED_W     = 32;
    localparam int VEL_W         = 32;
    localparam int PERIOD_W      = 20;
    localparam int CFG_W         = 24;
    localparam int CFG_IDX_W     = 3;

    // Derivative path: dividend is |error change| scaled by 2^16.
    localparam int DIFF_W        = POSITION_BITS + 2;
    localparam int DIVIDEND_W    = ERR_W + 16;
    localparam int DERIV_W       = DIVIDEND_W + 1;

    // Shared multiplier and accumulator.
    localparam int DL_BITS       = 24;
    localparam int OP_W          = (ERR_W > 26) ? ERR_W : 26;
    localparam int PROD_W        = OP_W + GAIN_W + 1;
    localparam int ACC_W         = ((POSITION_BITS > 24) ? POSITION_BITS : 24) + 37;
    localparam int FRAC_BITS     = 28;

    // Step period limits.
    localparam logic [PERIOD_W-1:0] PERIOD_STOP = 20'd1000000;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN  = 20'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN          = 3'd0,
        REG_KI_GAIN          = 3'd1,
        REG_KD_GAIN          = 3'd2,
        REG_INTEGRAL_LIMIT   = 3'd3,
        REG_INVERT_DIRECTION = 3'd4
    } reg_index_t;

    // Operand selection of the shared multiply-accumulate unit.
    typedef enum logic [2:0] {
        MAC_NONE = 3'd0,
        MAC_P    = 3'd1,
        MAC_I    = 3'd2,
        MAC_DL   = 3'd3,
        MAC_DH   = 3'd4
    } mac_sel_t;

    typedef struct packed {
        logic signed [POSITION_BITS-1:0] target_position;
        logic signed [POSITION_BITS-1:0] measured_position;
        logic [ELAPSED_W-1:0]            elapsed_us;
    } in_item_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] drive_velocity;
        logic                    drive_direction;
        logic [PERIOD_W-1:0]     step_period;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     sum_upd;
        mac_sel_t mac_sel;
        logic     div_start;
        logic     d_zero;
        logic     d_load;
        logic     vel_upd;
        logic     out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic elapsed_zero;
        logic div_done;
        logic out_free;
    } status_t;

    // 1000 / mag, truncated, for magnitudes one to nine; zero and larger magnitudes give the minimum.
    function automatic logic [PERIOD_W-1:0] period_lut(input logic [3:0] mag);
        logic [PERIOD_W-1:0] p;
        case (mag)
            4'd1:    p = 20'd1000;
            4'd2:    p = 20'd500;
            4'd3:    p = 20'd333;
            4'd4:    p = 20'd250;
            4'd5:    p = 20'd200;
            4'd6:    p = 20'd166;
            4'd7:    p = 20'd142;
            4'd8:    p = 20'd125;
            4'd9:    p = 20'd111;
            default: p = 20'd100;
        endcase
        return p;
    endfunction

endpackage

@@ hdl/pidsr_div.sv @@
// Bit-serial restoring divider for the derivative term, one quotient bit per cycle.
module pidsr_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pidsr_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [pidsr_pkg::ELAPSED_W-1:0]     divisor,
    output logic                                done,
    output logic [pidsr_pkg::DIVIDEND_W-1:0]    quotient
);

    localparam int N     = pidsr_pkg::DIVIDEND_W;
    localparam int DW    = pidsr_pkg::ELAPSED_W;
    localparam int CNT_W = $clog2(N);

    logic [N-1:0]     quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    divisor_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DW:0]      shifted;
    logic [DW+1:0]    trial;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[N-1]};
        trial   = {1'b0, shifted} - {2'b00, divisor_reg};
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == CNT_W'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N-2:0], ~trial[DW+1]};
            if (!trial[DW+1])
                rem_reg <= trial[DW-1:0];
            else
                rem_reg <= shifted[DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/pidsr_dp.sv @@
// Datapath: configuration, controller state, derivative divider, shared MAC and output register.
module pidsr_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [pidsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pidsr_pkg::CFG_W-1:0]        cfg_data,
    input  pidsr_pkg::in_item_t                in_data,
    input  pidsr_pkg::cmd_t                    cmd,
    output pidsr_pkg::status_t                 status,
    output logic                               out_valid,
    input  logic                               out_stall,
    output pidsr_pkg::out_item_t               out_data
);

    localparam int ERR_W   = pidsr_pkg::ERR_W;
    localparam int SUM_W   = pidsr_pkg::SUM_W;
    localparam int LIMIT_W = pidsr_pkg::LIMIT_W;
    localparam int GAIN_W  = pidsr_pkg::GAIN_W;
    localparam int DIFF_W  = pidsr_pkg::DIFF_W;
    localparam int DVD_W   = pidsr_pkg::DIVIDEND_W;
    localparam int DER_W   = pidsr_pkg::DERIV_W;
    localparam int OP_W    = pidsr_pkg::OP_W;
    localparam int PROD_W  = pidsr_pkg::PROD_W;
    localparam int ACC_W   = pidsr_pkg::ACC_W;
    localparam int FRAC    = pidsr_pkg::FRAC_BITS;
    localparam int DL      = pidsr_pkg::DL_BITS;
    localparam int VEL_W   = pidsr_pkg::VEL_W;
    localparam int QW      = ACC_W - FRAC;
    localparam int SUMX_W  = ((ERR_W > SUM_W) ? ERR_W : SUM_W) + 1;

    localparam logic signed [QW-1:0] VEL_MAX = {{(QW-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}};
    localparam logic signed [QW-1:0] VEL_MIN = {{(QW-VEL_W+1){1'b1}}, {(VEL_W-1){1'b0}}};

    // Configuration registers.
    logic [GAIN_W-1:0]  kp_gain_reg;
    logic [GAIN_W-1:0]  ki_gain_reg;
    logic [GAIN_W-1:0]  kd_gain_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               invert_reg;

    // Controller state and per-transaction working registers.
    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [ERR_W-1:0]  last_error_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic [pidsr_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DER_W-1:0]  d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    pidsr_pkg::mac_sel_t      prod_sel_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [VEL_W-1:0]  v_reg;
    logic                     out_valid_reg;
    pidsr_pkg::out_item_t     out_reg;

    logic signed [SUMX_W-1:0] sum_raw;
    logic signed [SUMX_W-1:0] lim_pos;
    logic signed [SUMX_W-1:0] lim_neg;
    logic signed [SUMX_W-1:0] sum_clamped;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [DIFF_W-1:0] diff_mag;
    logic [DVD_W-1:0]         dividend;
    logic                     div_done;
    logic [DVD_W-1:0]         quotient;
    logic signed [DER_W-1:0]  quo_ext;
    logic signed [OP_W-1:0]   mac_op;
    logic [GAIN_W-1:0]        mac_gain;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_addend;
    logic signed [QW-1:0]     q_floor;
    logic signed [QW-1:0]     q_trunc;
    logic                     q_round;
    logic signed [VEL_W-1:0]  v_next;
    logic                     v_small;
    logic [3:0]               v_mag;
    logic [pidsr_pkg::PERIOD_W-1:0] period_next;
    logic                     dir_next;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_gain_reg <= 16'd1229;
            ki_gain_reg <= 16'd2048;
            kd_gain_reg <= 16'd41;
            limit_reg   <= 24'd1;
            invert_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pidsr_pkg::REG_KP_GAIN:          kp_gain_reg <= cfg_data[GAIN_W-1:0];
                pidsr_pkg::REG_KI_GAIN:          ki_gain_reg <= cfg_data[GAIN_W-1:0];
                pidsr_pkg::REG_KD_GAIN:          kd_gain_reg <= cfg_data[GAIN_W-1:0];
                pidsr_pkg::REG_INTEGRAL_LIMIT:   limit_reg   <= cfg_data[LIMIT_W-1:0];
                pidsr_pkg::REG_INVERT_DIRECTION: invert_reg  <= cfg_data[0];
                default:                         ;
            endcase
        end
    end

    // Clamped integral and error change.
    always_comb
    begin
        sum_raw   = SUMX_W'(error_sum_reg) + SUMX_W'(err_reg);
        lim_pos   = $signed({{(SUMX_W-LIMIT_W){1'b0}}, limit_reg});
        lim_neg   = -lim_pos;
        if (sum_raw > lim_pos)
            sum_clamped = lim_pos;
        else if (sum_raw < lim_neg)
            sum_clamped = lim_neg;
        else
            sum_clamped = sum_raw;
        diff_next = DIFF_W'(err_reg) - DIFF_W'(last_error_reg);
    end

    // Integral and previous-error state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end
        else if (cmd.sum_upd)
        begin
            error_sum_reg  <= sum_clamped[SUM_W-1:0];
            last_error_reg <= err_reg;
        end
    end

    // Dividend is the error change magnitude scaled by 2^16.
    always_comb
    begin
        diff_mag = diff_reg[DIFF_W-1] ? -diff_reg : diff_reg;
        dividend = {diff_mag[ERR_W-1:0], 16'd0};
        quo_ext  = $signed({{(DER_W-DVD_W){1'b0}}, quotient});
    end

    pidsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (cmd.mac_sel)
            pidsr_pkg::MAC_P:
            begin
                mac_op   = OP_W'(err_reg);
                mac_gain = kp_gain_reg;
            end
            pidsr_pkg::MAC_I:
            begin
                mac_op   = OP_W'(error_sum_reg);
                mac_gain = ki_gain_reg;
            end
            pidsr_pkg::MAC_DL:
            begin
                mac_op   = $signed({{(OP_W-DL){1'b0}}, d_reg[DL-1:0]});
                mac_gain = kd_gain_reg;
            end
            pidsr_pkg::MAC_DH:
            begin
                mac_op   = OP_W'(d_reg >>> DL);
                mac_gain = kd_gain_reg;
            end
            default:
            begin
                mac_op   = '0;
                mac_gain = '0;
            end
        endcase
        prod_next = mac_op * $signed({1'b0, mac_gain});
    end

    // Product weighting before accumulation.
    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        case (prod_sel_reg) inside
            pidsr_pkg::MAC_P,
            pidsr_pkg::MAC_I:  acc_addend = prod_ext <<< 16;
            pidsr_pkg::MAC_DL: acc_addend = prod_ext;
            pidsr_pkg::MAC_DH: acc_addend = prod_ext <<< DL;
            default:           acc_addend = '0;
        endcase
    end

    // Velocity: truncate the Q.28 sum toward zero, then saturate.
    always_comb
    begin
        q_floor = acc_reg[ACC_W-1:FRAC];
        q_round = acc_reg[ACC_W-1] && (acc_reg[FRAC-1:0] != '0);
        q_trunc = q_floor + $signed({{(QW-1){1'b0}}, q_round});
        if (q_trunc > VEL_MAX)
            v_next = VEL_MAX[VEL_W-1:0];
        else if (q_trunc < VEL_MIN)
            v_next = VEL_MIN[VEL_W-1:0];
        else
            v_next = q_trunc[VEL_W-1:0];
    end

    // Direction and step period from the velocity.
    always_comb
    begin
        v_small  = (v_reg > -32'sd10) && (v_reg < 32'sd10);
        v_mag    = v_reg[VEL_W-1] ? (~v_reg[3:0] + 4'd1) : v_reg[3:0];
        dir_next = (!v_reg[VEL_W-1] && (v_reg != '0)) ^ invert_reg;
        if (v_reg == '0)
            period_next = pidsr_pkg::PERIOD_STOP;
        else if (v_small)
            period_next = pidsr_pkg::period_lut(v_mag);
        else
            period_next = pidsr_pkg::PERIOD_MIN;
    end

    // Working registers of one transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg     <= ERR_W'(in_data.target_position) - ERR_W'(in_data.measured_position);
            elapsed_reg <= in_data.elapsed_us;
        end
        if (cmd.sum_upd)
            diff_reg <= diff_next;
        if (cmd.d_zero)
            d_reg <= '0;
        else if (cmd.d_load)
            d_reg <= diff_reg[DIFF_W-1] ? -quo_ext : quo_ext;
        prod_reg <= prod_next;
        if (cmd.load)
            acc_reg <= '0;
        else
            acc_reg <= acc_reg + acc_addend;
        if (cmd.vel_upd)
            v_reg <= v_next;
        if (cmd.out_load)
        begin
            out_reg.drive_velocity  <= v_reg;
            out_reg.drive_direction <= dir_next;
            out_reg.step_period     <= period_next;
        end
    end

    // Product tag and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_sel_reg  <= pidsr_pkg::MAC_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prod_sel_reg <= cmd.mac_sel;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.elapsed_zero = (elapsed_reg == '0);
    assign status.div_done     = div_done;
    assign status.out_free     = !out_valid_reg || !out_stall;
    assign out_valid           = out_valid_reg;
    assign out_data            = out_reg;

endmodule

@@ hdl/pidsr_ctrl.sv @@
// Controller state machine sequencing one update through the datapath.
module pidsr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pidsr_pkg::status_t status,
    output pidsr_pkg::cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SUM   = 9'b000000010,
        ST_DIVS  = 9'b000000100,
        ST_DIVW  = 9'b000001000,
        ST_MDL   = 9'b000010000,
        ST_MDH   = 9'b000100000,
        ST_DRAIN = 9'b001000000,
        ST_VEL   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mac_sel   = pidsr_pkg::MAC_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_upd = 1'b1;
                cmd.mac_sel = pidsr_pkg::MAC_P;
                state_next  = ST_DIVS;
            end
            ST_DIVS:
            begin
                cmd.mac_sel = pidsr_pkg::MAC_I;
                if (status.elapsed_zero)
                begin
                    cmd.d_zero = 1'b1;
                    state_next = ST_MDL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (status.div_done)
                begin
                    cmd.d_load = 1'b1;
                    state_next = ST_MDL;
                end
            end
            ST_MDL:
            begin
                cmd.mac_sel = pidsr_pkg::MAC_DL;
                state_next  = ST_MDH;
            end
            ST_MDH:
            begin
                cmd.mac_sel = pidsr_pkg::MAC_DH;
                state_next  = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_VEL;
            end
            ST_VEL:
            begin
                cmd.vel_upd = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

@@ hdl/pid_step_rate_controller.sv @@
// One transaction is in flight at a time; when elapsed_us is nonzero, the bit-serial
// derivative divider (41-bit dividend, one quotient bit per cycle) sets the time per
// transaction. When elapsed_us is zero the divider is skipped.
// The result register holds a finished transaction while the next update computes.
// Reset clears the integral, the previous error, the control state and loads the
// default gains, limit and direction setting.
module pid_step_rate_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [pidsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pidsr_pkg::CFG_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  pidsr_pkg::in_item_t                in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output pidsr_pkg::out_item_t               out_data
);

    pidsr_pkg::cmd_t    cmd;
    pidsr_pkg::status_t status;

    pidsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pidsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // The block goes busy right after taking a transaction.
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> in_stall)
        else $error("block did not go busy after accepting a transaction");

    // Divider completion is only ever seen while the controller waits for it.
    a_div_done_taken: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> cmd.d_load)
        else $error("divider result was not taken");

    // Sequencing commands belong to distinct steps.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.sum_upd, cmd.div_start | cmd.d_zero, cmd.vel_upd,
                  cmd.out_load}))
        else $error("conflicting sequencing commands");

    // A loaded result is presented on the next cycle.
    a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result register load did not raise out_valid");

endmodule
